@@ src/ddt_pkg.sv @@
`default_nettype none
package ddt_pkg;

    localparam logic [1:0] OP_DEFER   = 2'd0;
    localparam logic [1:0] OP_PROCESS = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [7:0] DEFAULT_BATCH = 8'd32;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] object_handle;
        logic [7:0]  visit_limit;
    } t_in_item;

    typedef struct packed {
        logic [6:0] pending_entries;
        logic       threshold_reached;
        logic       insert_dropped;
        logic [6:0] entries_visited;
        logic [6:0] entries_released;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic rd;
        logic adv;
        logic bump;
        logic insert;
        logic drop;
        logic cstep;
        logic cfin;
        logic flush;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       zero_handle;
        logic       full;
        logic       search_end;
        logic       hit;
        logic       proc_empty;
        logic       last;
        logic       out_free;
    } t_status;

endpackage
`default_nettype wire

@@ src/deferred_decrement_table.sv @@
`default_nettype none
// Deferred decrement table: an ordered ring of (handle, count) entries, newest
// first. Each item runs alone. A defer scans entries from the head, reading
// and then checking each entry in turn. A process walks min(visit_limit,
// live) entries from the deepest visited one toward the head, reading and
// then stepping each entry, compacting kept entries in place. Flush, no-op
// and a defer of handle zero go straight to the output, as does a process
// that visits nothing. A new item is taken while the previous result still
// waits on the output register.
module deferred_decrement_table
    import ddt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int HANDLE_BITS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire t_in_item   i_in_item,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output t_out_item       o_out_item,
    input  wire logic       i_out_stall,
    input  wire logic       i_cfg_valid,
    input  wire logic [7:0] i_cfg_data,
    output logic            o_cfg_ready
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    ddt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    ddt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

@@ src/ddt_ctrl.sv @@
`default_nettype none
module ddt_ctrl
    import ddt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_in_stall
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DISPATCH, ST_S_RD, ST_S_EV, ST_C_RD, ST_C_EV, ST_C_FIN, ST_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (i_status.op)
                    OP_DEFER:   n_state = i_status.zero_handle ? ST_OUT : ST_S_RD;
                    OP_PROCESS: n_state = i_status.proc_empty ? ST_OUT : ST_C_RD;
                    OP_FLUSH: begin
                        o_cmd.flush = 1'b1;
                        n_state     = ST_OUT;
                    end
                    default:    n_state = ST_OUT;
                endcase
            end
            ST_S_RD: begin
                if (i_status.search_end) begin
                    if (i_status.full) o_cmd.drop = 1'b1;
                    else               o_cmd.insert = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_S_EV;
                end
            end
            ST_S_EV: begin
                if (i_status.hit) begin
                    o_cmd.bump = 1'b1;
                    n_state    = ST_OUT;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = ST_S_RD;
                end
            end
            ST_C_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_C_EV;
            end
            ST_C_EV: begin
                o_cmd.cstep = 1'b1;
                n_state     = i_status.last ? ST_C_FIN : ST_C_RD;
            end
            ST_C_FIN: begin
                o_cmd.cfin = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule
`default_nettype wire

@@ src/ddt_datapath.sv @@
`default_nettype none
module ddt_datapath
    import ddt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int HANDLE_BITS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_in_item,
    input  wire logic     i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic     i_out_stall,
    input  wire t_cmd     i_cmd,
    output t_status       o_status,
    output logic          o_out_valid,
    output t_out_item     o_out_item
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam logic [LW:0] DEPTH_W = (LW + 1)'(TABLE_DEPTH);
    localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [HANDLE_BITS-1:0] mem_h [TABLE_DEPTH];
    logic [COUNT_BITS-1:0]  mem_c [TABLE_DEPTH];

    logic [IW-1:0]          r_head;
    logic [LW-1:0]          r_live, r_pos, r_wr, r_visited, r_released;
    logic                   r_dropped;
    logic [1:0]             r_op;
    logic [HANDLE_BITS-1:0] r_handle, r_rd_handle;
    logic [COUNT_BITS-1:0]  r_rd_count;
    logic [7:0]             r_batch;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    // map a position from the head to a physical slot of the ring
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [LW-1:0] p);
        logic [LW:0] s;
        s = (LW + 1)'(head) + (LW + 1)'(p);
        if (s >= DEPTH_W) s = s - DEPTH_W;
        return s[IW-1:0];
    endfunction

    logic [HANDLE_BITS-1:0] in_handle;
    logic [LW-1:0]          lim;
    logic [IW-1:0]          rd_addr, head_dec;
    logic [COUNT_BITS-1:0]  cnt_dec;
    logic                   out_free;
    logic [7:0]             thr;

    always_comb begin
        in_handle = HANDLE_BITS'(i_in_item.object_handle);
        if (32'(i_in_item.visit_limit) < 32'(r_live)) lim = LW'(i_in_item.visit_limit);
        else                                          lim = r_live;
        rd_addr  = phys(r_head, (r_op == OP_PROCESS) ? r_pos - 1'b1 : r_pos);
        head_dec = (r_head == '0) ? IW'(TABLE_DEPTH - 1) : r_head - 1'b1;
        cnt_dec  = (r_rd_count != '0) ? r_rd_count - 1'b1 : r_rd_count;
        out_free = !r_out_valid || !i_out_stall;
        thr      = (r_batch == 8'd0) ? DEFAULT_BATCH : r_batch;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_handle <= mem_h[rd_addr];
            r_rd_count  <= mem_c[rd_addr];
        end
        if (i_cmd.insert) begin
            mem_h[head_dec] <= r_handle;
            mem_c[head_dec] <= COUNT_BITS'(1);
        end else if (i_cmd.bump) begin
            mem_c[rd_addr] <= (r_rd_count != COUNT_MAX) ? r_rd_count + 1'b1 : r_rd_count;
        end else if (i_cmd.cstep && cnt_dec != '0) begin
            mem_h[phys(r_head, r_wr)] <= r_rd_handle;
            mem_c[phys(r_head, r_wr)] <= cnt_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_in_item.operation;
            r_handle   <= in_handle;
            r_pos      <= (i_in_item.operation == OP_PROCESS) ? lim : '0;
            r_wr       <= lim - 1'b1;
            r_visited  <= '0;
            r_released <= '0;
            r_dropped  <= 1'b0;
        end
        if (i_cmd.adv) r_pos <= r_pos + 1'b1;
        if (i_cmd.drop) r_dropped <= 1'b1;
        if (i_cmd.cstep) begin
            r_pos     <= r_pos - 1'b1;
            r_visited <= r_visited + 1'b1;
            if (cnt_dec == '0) r_released <= r_released + 1'b1;
            else               r_wr <= r_wr - 1'b1;
        end
        if (i_cmd.flush) r_released <= r_live;
        if (i_cmd.emit) begin
            r_out_item.pending_entries   <= 7'(r_live);
            r_out_item.threshold_reached <= (32'(r_live) >= 32'(thr));
            r_out_item.insert_dropped    <= r_dropped;
            r_out_item.entries_visited   <= 7'(r_visited);
            r_out_item.entries_released  <= 7'(r_released);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_live      <= '0;
            r_batch     <= DEFAULT_BATCH;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_batch <= i_cfg_data;
            if (i_cmd.insert) begin
                r_head <= head_dec;
                r_live <= r_live + 1'b1;
            end
            // drop the released slots off the head side of the ring
            if (i_cmd.cfin) begin
                r_head <= phys(r_head, r_released);
                r_live <= r_live - r_released;
            end
            if (i_cmd.flush) r_live <= '0;
            if (i_cmd.emit)          r_out_valid <= 1'b1;
            else if (!i_out_stall)   r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_status.op          = r_op;
        o_status.zero_handle = (r_handle == '0);
        o_status.full        = (r_live == DEPTH_L);
        o_status.search_end  = (r_pos == r_live);
        o_status.hit         = (r_rd_handle == r_handle);
        o_status.proc_empty  = (r_pos == '0);
        o_status.last        = (r_pos == LW'(1));
        o_status.out_free    = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= DEPTH_L) else $error("live count beyond table depth");
    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> r_live == '0) else $error("flush left entries");
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |=> r_live == $past(r_live) + 1'b1) else $error("insert miscount");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free) else $error("result overwritten");
    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> r_live != DEPTH_L) else $error("insert into full table");
`endif

endmodule
`default_nettype wire
